FILE: rtl/ljfh_pkg.sv
package ljfh_pkg;

  localparam int DIST_FRAC_BITS = 24;

  localparam int MUL_LAT = 3;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT = DIV_STEPS + 1;

  localparam logic [63:0] MAG_MAX = '1;

  // hbar^2 / (24 kB amu) in Q8.24, scaled by 2^40 as a 128-bit numerator
  localparam logic [63:0] FH_C2 = 64'd33910064;
  localparam logic [63:0] C2_HI = FH_C2 >> 24;
  localparam logic [63:0] C2_LO = FH_C2 << 40;

  localparam logic [2:0] REG_SPECTRE = 3'd0;
  localparam logic [2:0] REG_DISP_OFF = 3'd1;
  localparam logic [2:0] REG_REP_MODE = 3'd2;
  localparam logic [2:0] REG_FH_ORDER = 3'd3;
  localparam logic [2:0] REG_CUTOFF = 3'd4;
  localparam logic [2:0] REG_MARGIN = 3'd5;
  localparam logic [2:0] REG_TEMP = 3'd6;

  localparam logic [1:0] FH_OFF = 2'd0;
  localparam logic [1:0] FH_2ND = 2'd1;
  localparam logic [1:0] FH_4TH = 2'd2;
  localparam logic [1:0] FH_RSVD = 2'd3;

  localparam logic [31:0] CUTOFF_RST = 32'd167772160;
  localparam logic [15:0] MARGIN_RST = 16'd1;
  localparam logic [31:0] TEMP_RST = 32'd19529728;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        sat;
  } sval_t;

  function automatic sval_t mkv(input logic [63:0] m);
    sval_t v;
    v.mag = m;
    v.neg = 1'b0;
    v.sat = 1'b0;
    return v;
  endfunction

  function automatic sval_t negv(input sval_t x);
    sval_t v;
    v = x;
    if (x.mag != '0) v.neg = ~x.neg;
    return v;
  endfunction

  function automatic sval_t addv(input sval_t x, input sval_t y);
    sval_t r;
    logic [64:0] sum;
    r = mkv('0);
    sum = '0;
    if (x.sat) begin
      r = x;
    end else if (y.sat) begin
      r = y;
    end else begin
      if (x.neg == y.neg) begin
        sum = {1'b0, x.mag} + {1'b0, y.mag};
        r.neg = x.neg;
        if (sum[64]) begin
          r.mag = MAG_MAX;
          r.sat = 1'b1;
        end else begin
          r.mag = sum[63:0];
        end
      end else if (x.mag >= y.mag) begin
        r.mag = x.mag - y.mag;
        r.neg = x.neg;
      end else begin
        r.mag = y.mag - x.mag;
        r.neg = y.neg;
      end
      if (r.mag == '0) r.neg = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/ljfh_if.sv
interface ljfh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pair_distance;
  logic [31:0] pair_sigma;
  logic [31:0] pair_epsilon;
  logic [31:0] repulsion_coeff;
  logic [31:0] mass_first;
  logic [31:0] mass_second;
  logic        attr_only;
  logic        excluded_pair;
  logic        frozen_pair;

  modport source (
    output valid, pair_distance, pair_sigma, pair_epsilon, repulsion_coeff,
           mass_first, mass_second, attr_only, excluded_pair, frozen_pair,
    input  ready
  );
  modport sink (
    input  valid, pair_distance, pair_sigma, pair_epsilon, repulsion_coeff,
           mass_first, mass_second, attr_only, excluded_pair, frozen_pair,
    output ready
  );
endinterface

interface ljfh_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] pair_energy;
  logic               included;
  logic               saturated;

  modport source (output valid, pair_energy, included, saturated, input ready);
  modport sink (input valid, pair_energy, included, saturated, output ready);
endinterface

FILE: rtl/lj_pair_energy_fh.sv
// Lennard-Jones 12-6 pair energy with optional Feynman-Hibbs correction.
// in_ch carries one atom pair per item (distance, sigma, epsilon, repulsion
// coefficient, both masses, pair flags); out_ch returns one result item per
// pair: Q40.24 energy, included and saturated flags, in arrival order.
// Items are taken at edges where valid and ready are both high.
// Throughput is one item per clock while in_ch.ready is high: every divider
// is a 64-stage pipeline retiring one quotient bit per stage and every
// multiplier is a 3-stage 32x32 partial-product pipeline, so nothing is
// reused between items. The delay from the accepting edge to out_ch.valid
// is set by the chain of four dividers and five multiplies on the
// reduced-mass and correction path (the sigma/r path runs alongside).
// Config writes on cfg_we/cfg_idx/cfg_data take effect at once; the user must
// see that they are only made while the block is empty, which it does not check.
// rst_n (synchronous, active low) clears all valid bits and loads the
// register defaults; no clearing pass is needed.
// When out_ch stalls the item in flight is caught in a skid register and
// the whole pipeline then holds; in_ch.ready drops until the skid drains.
module lj_pair_energy_fh (
  input  logic               clk,
  input  logic               rst_n,
  ljfh_in_if.sink            in_ch,
  ljfh_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data
);
  import ljfh_pkg::*;

  localparam int T_MU_D = MUL_LAT;
  localparam int T_TKMU = T_MU_D + DIV_LAT;
  localparam int T_G0 = T_TKMU + MUL_LAT;
  localparam int T_G1 = T_G0 + DIV_LAT;
  localparam int T_G2 = T_G1 + DIV_LAT;
  localparam int T_G = T_G2 + DIV_LAT;
  localparam int T_T = T_G - 1;
  localparam int T_S = T_T - 4 * MUL_LAT - DIV_LAT;
  localparam int T_CLS = T_T + MUL_LAT + 1;
  localparam int T_CS = T_CLS + 2 * MUL_LAT + 1;
  localparam int T_E = T_CS + 1;
  localparam int SIDE_DEPTH = T_E + 1;
  localparam int E_DLY = T_CS - T_CLS;

  typedef struct packed {
    logic        incl;
    logic        attr;
    logic [31:0] sigma;
    logic [31:0] rr;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [32:0] msum;
    logic [33:0] a_val;
  } side_t;

  typedef struct packed {
    logic [63:0] energy;
    logic        incl;
    logic        sat;
  } out_t;

  logic        spectre_r, disp_off_r, rep_mode_r;
  logic [1:0]  fh_r;
  logic [31:0] cutoff_r, temp_r;
  logic [15:0] margin_r;

  logic                  adv;
  logic [SIDE_DEPTH-1:0] vld_r;
  side_t                 side_r [SIDE_DEPTH];
  side_t                 side_in;
  logic                  in_range;
  logic [31:0]           a1, a2;

  sval_t       mm_p, tm_p, g0_v, g1_v, g_v, s_v, s_d, s2, s3, s6, s6_d, s12;
  logic [63:0] mu_q, mu, g0_q, g1_q, g_q, s_q;
  logic        g0_sat, g1_sat, g_sat, mu_sat, s_sat;
  logic [31:0] tk;
  sval_t       t12, t6, a_t, a_g;
  sval_t       at12, at6, spe, k132, k30, k11922, k795;
  sval_t       ecls_r, b2_r, b4_r, ga, g_d, c, gag, b4_d, c4, c_d, csum_r, e_r;
  sval_t       edl_r [E_DLY];
  out_t        res, o_r, sk_r;
  logic        o_valid_r, sk_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spectre_r <= 1'b0;
      disp_off_r <= 1'b0;
      rep_mode_r <= 1'b0;
      fh_r <= FH_OFF;
      cutoff_r <= CUTOFF_RST;
      margin_r <= MARGIN_RST;
      temp_r <= TEMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SPECTRE:  spectre_r <= cfg_data[0];
        REG_DISP_OFF: disp_off_r <= cfg_data[0];
        REG_REP_MODE: rep_mode_r <= cfg_data[0];
        REG_FH_ORDER: fh_r <= cfg_data[1:0];
        REG_CUTOFF:   cutoff_r <= cfg_data;
        REG_MARGIN:   margin_r <= cfg_data[15:0];
        REG_TEMP:     temp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv = !sk_valid_r;
  assign in_ch.ready = adv;

  // pair qualification and operand set-up
  always_comb begin
    in_range = (in_ch.pair_distance < {16'b0, margin_r}) ||
               ((in_ch.pair_distance - {16'b0, margin_r}) < cutoff_r);
    a1 = (in_ch.mass_first == '0) ? 32'd1 : in_ch.mass_first;
    a2 = (in_ch.mass_second == '0) ? 32'd1 : in_ch.mass_second;
    side_in.incl = in_range && !in_ch.excluded_pair && !in_ch.frozen_pair;
    side_in.attr = in_ch.attr_only;
    side_in.sigma = in_ch.pair_sigma;
    side_in.rr = (in_ch.pair_distance == '0) ? 32'd1 : in_ch.pair_distance;
    side_in.m1 = a1;
    side_in.m2 = a2;
    side_in.msum = {1'b0, a1} + {1'b0, a2};
    side_in.a_val = rep_mode_r ? {2'b0, in_ch.repulsion_coeff} : {in_ch.pair_epsilon, 2'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SIDE_DEPTH-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // reduced mass and quantum prefactor
  ljfh_vmul u_mm (
    .clk(clk), .en(adv), .x(mkv({32'b0, side_r[0].m1})), .y(mkv({32'b0, side_r[0].m2})),
    .sh(6'd0), .p(mm_p)
  );

  ljfh_div u_dmu (
    .clk(clk), .en(adv), .n_hi(64'd0), .n_lo(mm_p.mag), .den({31'b0, side_r[T_MU_D].msum}),
    .force_sat(1'b0), .force_zero(1'b0), .quo(mu_q), .q_sat(mu_sat)
  );

  assign mu = (mu_q == '0) ? 64'd1 : {32'b0, mu_q[31:0]};
  assign tk = (temp_r == '0) ? 32'd1 : temp_r;

  ljfh_vmul u_tm (
    .clk(clk), .en(adv), .x(mkv({32'b0, tk})), .y(mkv(mu)), .sh(6'd0), .p(tm_p)
  );

  ljfh_div u_dg0 (
    .clk(clk), .en(adv), .n_hi(C2_HI), .n_lo(C2_LO), .den(tm_p.mag),
    .force_sat(1'b0), .force_zero(1'b0), .quo(g0_q), .q_sat(g0_sat)
  );
  assign g0_v = '{mag: g0_q, neg: 1'b0, sat: g0_sat};

  ljfh_div u_dg1 (
    .clk(clk), .en(adv), .n_hi(g0_v.mag >> (64 - DIST_FRAC_BITS)),
    .n_lo(g0_v.mag << DIST_FRAC_BITS), .den({32'b0, side_r[T_G1].rr}),
    .force_sat(g0_v.sat), .force_zero(g0_v.mag == '0), .quo(g1_q), .q_sat(g1_sat)
  );
  assign g1_v = '{mag: g1_q, neg: 1'b0, sat: g1_sat};

  ljfh_div u_dg2 (
    .clk(clk), .en(adv), .n_hi(g1_v.mag >> (64 - DIST_FRAC_BITS)),
    .n_lo(g1_v.mag << DIST_FRAC_BITS), .den({32'b0, side_r[T_G2].rr}),
    .force_sat(g1_v.sat), .force_zero(g1_v.mag == '0), .quo(g_q), .q_sat(g_sat)
  );
  assign g_v = '{mag: g_q, neg: 1'b0, sat: g_sat};

  // sigma over r and its powers
  ljfh_div u_ds (
    .clk(clk), .en(adv), .n_hi(64'd0), .n_lo({side_r[T_S].sigma, 32'b0}),
    .den({32'b0, side_r[T_S].rr}), .force_sat(1'b0), .force_zero(1'b0),
    .quo(s_q), .q_sat(s_sat)
  );
  assign s_v = '{mag: s_q, neg: 1'b0, sat: s_sat};

  ljfh_vmul u_s2 (.clk(clk), .en(adv), .x(s_v), .y(s_v), .sh(6'd32), .p(s2));
  ljfh_sdly u_sd (.clk(clk), .en(adv), .d(s_v), .q(s_d));
  ljfh_vmul u_s3 (.clk(clk), .en(adv), .x(s2), .y(s_d), .sh(6'd32), .p(s3));
  ljfh_vmul u_s6 (.clk(clk), .en(adv), .x(s3), .y(s3), .sh(6'd32), .p(s6));
  ljfh_vmul u_s12 (.clk(clk), .en(adv), .x(s6), .y(s6), .sh(6'd32), .p(s12));
  ljfh_sdly u_s6d (.clk(clk), .en(adv), .d(s6), .q(s6_d));

  // classical terms and correction brackets
  assign t12 = (!spectre_r && side_r[T_T].attr) ? mkv('0) : s12;
  assign t6 = (spectre_r || disp_off_r) ? mkv('0) : s6_d;
  assign a_t = mkv({30'b0, side_r[T_T].a_val});
  assign a_g = mkv({30'b0, side_r[T_G].a_val});

  ljfh_vmul u_at12 (.clk(clk), .en(adv), .x(a_t), .y(t12), .sh(6'd24), .p(at12));
  ljfh_vmul u_at6 (.clk(clk), .en(adv), .x(a_t), .y(t6), .sh(6'd24), .p(at6));
  ljfh_vmul u_spe (.clk(clk), .en(adv), .x(t12), .y(mkv(64'd1)), .sh(6'd8), .p(spe));
  ljfh_vmul u_k132 (.clk(clk), .en(adv), .x(mkv(64'd132)), .y(t12), .sh(6'd0), .p(k132));
  ljfh_vmul u_k30 (.clk(clk), .en(adv), .x(mkv(64'd30)), .y(t6), .sh(6'd0), .p(k30));
  ljfh_vmul u_k11922 (
    .clk(clk), .en(adv), .x(mkv(64'd11922)), .y(t12), .sh(6'd0), .p(k11922)
  );
  ljfh_vmul u_k795 (.clk(clk), .en(adv), .x(mkv(64'd795)), .y(t6), .sh(6'd0), .p(k795));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (spectre_r) begin
        ecls_r <= spe;
      end else if (rep_mode_r) begin
        ecls_r <= at12;
      end else begin
        ecls_r <= addv(at12, negv(at6));
      end
      b2_r <= addv(k132, negv(k30));
      b4_r <= addv(k11922, negv(k795));
    end
  end

  ljfh_vmul u_ga (.clk(clk), .en(adv), .x(g_v), .y(a_g), .sh(6'd16), .p(ga));
  ljfh_sdly u_gd (.clk(clk), .en(adv), .d(g_v), .q(g_d));
  ljfh_vmul u_c (.clk(clk), .en(adv), .x(ga), .y(b2_r), .sh(6'd40), .p(c));
  ljfh_vmul u_gag (.clk(clk), .en(adv), .x(ga), .y(g_d), .sh(6'd32), .p(gag));
  ljfh_sdly u_b4d (.clk(clk), .en(adv), .d(b4_r), .q(b4_d));
  ljfh_vmul u_c4 (.clk(clk), .en(adv), .x(gag), .y(b4_d), .sh(6'd40), .p(c4));
  ljfh_sdly u_cd (.clk(clk), .en(adv), .d(c), .q(c_d));

  // final sums
  always_ff @(posedge clk) begin
    if (adv) begin
      edl_r[0] <= ecls_r;
      for (int i = 1; i < E_DLY; i++) begin
        edl_r[i] <= edl_r[i-1];
      end
      csum_r <= (fh_r == FH_4TH) ? addv(c4, c_d) : c_d;
      e_r <= ((fh_r == FH_2ND) || (fh_r == FH_4TH)) ? addv(csum_r, edl_r[E_DLY-1])
                                                     : edl_r[E_DLY-1];
    end
  end

  always_comb begin
    res.incl = side_r[T_E].incl;
    res.energy = '0;
    res.sat = 1'b0;
    if (side_r[T_E].incl) begin
      if (e_r.sat || (!e_r.neg && e_r.mag[63]) ||
          (e_r.neg && (e_r.mag > {1'b1, 63'b0}))) begin
        res.energy = e_r.neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        res.sat = 1'b1;
      end else begin
        res.energy = e_r.neg ? (64'd0 - e_r.mag) : e_r.mag;
      end
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      sk_valid_r <= 1'b0;
    end else if (out_ch.ready || !o_valid_r) begin
      if (sk_valid_r) begin
        o_valid_r <= 1'b1;
        sk_valid_r <= 1'b0;
      end else begin
        o_valid_r <= vld_r[T_E];
      end
    end else if (vld_r[T_E] && !sk_valid_r) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !o_valid_r) begin
      o_r <= sk_valid_r ? sk_r : res;
    end else if (!sk_valid_r) begin
      sk_r <= res;
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.pair_energy = o_r.energy;
  assign out_ch.included = o_r.incl;
  assign out_ch.saturated = o_r.sat;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> o_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_valid_r) |-> $past(o_valid_r && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.included) |-> (out_ch.pair_energy == '0 && !out_ch.saturated))
    else $error("rejected pair carries a non-zero result");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.pair_energy == {1'b1, 63'b0} || out_ch.pair_energy == {1'b0, {63{1'b1}}}))
    else $error("saturated energy is not on a rail");

endmodule

FILE: rtl/ljfh_div.sv
module ljfh_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_hi,
  input  logic [63:0] n_lo,
  input  logic [63:0] den,
  input  logic        force_sat,
  input  logic        force_zero,
  output logic [63:0] quo,
  output logic        q_sat
);
  import ljfh_pkg::*;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] den;
    logic        sat;
    logic        zero;
  } dstage_t;

  dstage_t st_r [DIV_LAT];

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t n;
    logic carry;
    n = s;
    carry = s.rem[63];
    n.rem = {s.rem[62:0], s.lo[63]};
    n.lo = {s.lo[62:0], 1'b0};
    if (carry || (n.rem >= s.den)) begin
      n.rem = n.rem - s.den;
      n.lo[0] = 1'b1;
    end
    return n;
  endfunction

  // one quotient bit per stage, quotient shifts into the low word
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem <= n_hi;
      st_r[0].lo <= n_lo;
      st_r[0].den <= den;
      st_r[0].sat <= force_sat || (n_hi >= den);
      st_r[0].zero <= force_zero;
      for (int i = 1; i < DIV_LAT; i++) begin
        st_r[i] <= div_step(st_r[i-1]);
      end
    end
  end

  always_comb begin
    if (st_r[DIV_LAT-1].zero) begin
      quo = '0;
      q_sat = 1'b0;
    end else if (st_r[DIV_LAT-1].sat) begin
      quo = MAG_MAX;
      q_sat = 1'b1;
    end else begin
      quo = st_r[DIV_LAT-1].lo;
      q_sat = 1'b0;
    end
  end

endmodule

FILE: rtl/ljfh_vmul.sv
module ljfh_vmul (
  input  logic             clk,
  input  logic             en,
  input  ljfh_pkg::sval_t  x,
  input  ljfh_pkg::sval_t  y,
  input  logic [5:0]       sh,
  output ljfh_pkg::sval_t  p
);
  import ljfh_pkg::*;

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] prod_r;
  logic [2:0]   f1_r, f2_r;
  logic [127:0] shp;
  sval_t        res;
  sval_t        p_r;

  // flags: zero, any saturated, sign
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= x.mag[31:0] * y.mag[31:0];
      lh_r <= x.mag[31:0] * y.mag[63:32];
      hl_r <= x.mag[63:32] * y.mag[31:0];
      hh_r <= x.mag[63:32] * y.mag[63:32];
      f1_r <= {(x.mag == '0) || (y.mag == '0), x.sat || y.sat, x.neg ^ y.neg};
      prod_r <= {hh_r, ll_r} + ({64'b0, lh_r} << 32) + ({64'b0, hl_r} << 32);
      f2_r <= f1_r;
      p_r <= res;
    end
  end

  always_comb begin
    shp = prod_r >> sh;
    res = mkv('0);
    if (!f2_r[2]) begin
      res.neg = f2_r[0];
      if (f2_r[1] || (shp[127:64] != '0)) begin
        res.mag = MAG_MAX;
        res.sat = 1'b1;
      end else begin
        res.mag = shp[63:0];
        if (shp[63:0] == '0) res.neg = 1'b0;
      end
    end
  end

  assign p = p_r;

endmodule

FILE: rtl/ljfh_sdly.sv
module ljfh_sdly (
  input  logic            clk,
  input  logic            en,
  input  ljfh_pkg::sval_t d,
  output ljfh_pkg::sval_t q
);
  import ljfh_pkg::*;

  sval_t dl_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= d;
      for (int i = 1; i < MUL_LAT; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign q = dl_r[MUL_LAT-1];

endmodule
